// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i, emptied for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define HSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define HSPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HSPD_ASSERT(lbl, prop, msg)
`define HSPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/hspd_pkg.sv =====
// ----------------------------------------------------------------------------
// hspd_pkg
// Shared types and constants for the header sync packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hspd_pkg;

  // Bytes in one packet, header and checksum included (4 to 10).
  localparam int unsigned PacketLength = 10;
  // Cells in the chain: one per payload byte (bytes 2 to PacketLength-1).
  localparam int unsigned CellCount    = PacketLength - 2;
  localparam int unsigned FillW        = $clog2(PacketLength);
  localparam int unsigned IdxW         = 4;
  localparam int unsigned SumW         = 7;

  typedef logic [7:0]       byte_t;
  typedef logic [FillW-1:0] fill_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [SumW-1:0]  sum_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== sv/hspd_cell.sv =====
// ----------------------------------------------------------------------------
// hspd_cell
// One byte cell of the packet chain; loads d_i (its neighbour, or the input at the tail) on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hspd_cell
  import hspd_pkg::*;
(
  input  wire        clk_i,
  input  wire        shift_i,
  input  wire byte_t d_i,
  output byte_t      q_o
);

  byte_t data_q;
  byte_t data_d;

  // Hold unless the chain advances.
  assign data_d = shift_i ? d_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

`default_nettype wire

// ===== sv/header_sync_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// header_sync_packet_deframer
// Finds header-led fixed-length packets in a byte stream, checks the 7-bit
// sum and emits the payload bytes with bit 7 restored from the flags byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                               Per transfer
//   --------  ---------  ------------------------------------  ------------
//   s_*       in         tdata[7:0] data_byte                  one raw byte
//   m_*       out        tdata[3:0] byte_index,                one payload byte
//                        tdata[11:4] byte_value, tlast
//   cfg_*     in         cfg_wdata_i[7:0] module_id            one write
//
// Rate: one received byte per cycle while s_tready_o is high. A packet that
// passes its check then holds the input for PacketLength-2 output transfers,
// since the cell chain advances one byte per output transfer.
// Reset clears the control state and module_id; the cells are left
// undefined and are refilled by every packet before any byte is emitted.
// Stalls: s_tready_o drops for the whole output run and rises again in the
// cycle after the transfer that carries tlast.
//
`default_nettype none

`include "assert_macros.svh"

module header_sync_packet_deframer
  import hspd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: module_id
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i,
  // Byte stream in
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [7:0]  s_tdata_i,   // [7:0] data_byte
  // Restored payload out
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [15:0] m_tdata_o,   // [3:0] byte_index, [11:4] byte_value, [15:12] zero
  output logic        m_tlast_o    // last_byte
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  fill_t  fill_q,  fill_d;    // bytes held; zero while hunting for a header
  sum_t   sum_q,   sum_d;     // low 7 bits of the running byte sum
  byte_t  flags_q, flags_d;   // high-bit byte, shifted right per transfer
  idx_t   idx_q,   idx_d;     // index of the byte at the chain head
  byte_t  id_q;

  logic s_xfer, m_xfer;
  logic is_hdr, store, last_in, good, shift;

  byte_t cell_q [CellCount];

  // --------------------------------------------------------------------------
  // Cell chain: bytes enter at the tail and move one cell toward the head on
  // every store and every output transfer. Just before the checksum byte
  // goes in, cell 0 holds byte 1 (the flags); once it is in, cell 0 holds
  // byte 2, the next byte to send.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    byte_t cell_d;
    if (i == CellCount - 1) begin : g_tail
      assign cell_d = s_tdata_i;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end
    hspd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .d_i     (cell_d),
      .q_o     (cell_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= '0;
    end else if (cfg_we_i) begin
      id_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Framing control
  // --------------------------------------------------------------------------
  assign s_xfer  = s_tvalid_i & s_tready_o;
  assign m_xfer  = m_tvalid_o & m_tready_i;
  assign is_hdr  = (s_tdata_i == id_q);
  // A non-header byte is kept only inside a packet.
  assign store   = s_xfer & ~is_hdr & (fill_q != '0);
  assign last_in = store & (fill_q == fill_t'(PacketLength - 1));
  assign good    = last_in & (s_tdata_i[SumW-1:0] == sum_q);
  assign shift   = store | m_xfer;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    flags_d    = flags_q;
    idx_d      = idx_q;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;

    case (state_q)
      ST_COLLECT: begin
        s_tready_o = 1'b1;
        if (s_xfer) begin
          if (is_hdr) begin
            // A header always restarts the packet.
            fill_d = fill_t'(1);
            sum_d  = s_tdata_i[SumW-1:0];
          end else if (last_in) begin
            fill_d = '0;
          end else if (store) begin
            fill_d = fill_q + fill_t'(1);
            sum_d  = sum_q + s_tdata_i[SumW-1:0];
          end
        end
        if (good) begin
          // Byte 1 leaves cell 0 on this same edge.
          flags_d = cell_q[0];
          idx_d   = idx_t'(2);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_tvalid_o = 1'b1;
        if (m_xfer) begin
          flags_d = flags_q >> 1;
          idx_d   = idx_q + idx_t'(1);
          if (m_tlast_o) begin
            state_d = ST_COLLECT;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
      sum_q   <= '0;
      flags_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      flags_q <= flags_d;
      idx_q   <= idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output: restore bit 7 of the head byte from the current flag bit
  // --------------------------------------------------------------------------
  assign m_tdata_o = {4'b0000, flags_q[0], cell_q[0][6:0], idx_q};
  assign m_tlast_o = (idx_q == idx_t'(PacketLength - 1));

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HSPD_ASSERT(a_sides_exclusive, !(s_tready_o && m_tvalid_o), "input taken during output run")
  `HSPD_ASSERT(a_run_starts_at_two, $rose(m_tvalid_o) |-> (idx_q == idx_t'(2)), "run not at index 2")
  `HSPD_ASSERT(a_last_ends_run, (m_xfer && m_tlast_o) |=> (s_tready_o && !m_tvalid_o), "run did not end")
  `HSPD_ASSERT(a_fill_in_range, fill_q < fill_t'(PacketLength), "fill count out of range")
  `HSPD_ASSERT(a_good_clears_fill, good |=> (fill_q == '0 && m_tvalid_o), "good packet not handed over")

endmodule

`default_nettype wire
